// ===== rtl/core/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpt_pkg: shared definitions of the two-level page table engine
// Table sizes, field widths, status codes and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int DIR_ENTRIES   = 1024;
    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_SLOTS   = 16;

    localparam int PAGE_W   = 20;
    localparam int FLAG_W   = 9;
    localparam int COUNT_W  = 21;
    localparam int STATUS_W = 2;

    // Index widths. Both table sizes are powers of two.
    localparam int DIR_W   = $clog2(DIR_ENTRIES);
    localparam int TAB_W   = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NF_W    = $clog2(TABLE_SLOTS + 1);
    localparam int TADDR_W = SLOT_W + TAB_W;
    localparam int TDEPTH  = 1 << TADDR_W;

    // Directory word: {present, slot}. Table word: {present, flags, page}.
    localparam int DWORD_W = 1 + SLOT_W;
    localparam int ENTRY_W = 1 + FLAG_W + PAGE_W;

    localparam logic [COUNT_W-1:0] MAX_RUN = COUNT_W'(1) << PAGE_W;

    localparam int IN_DATA_W  = ((2 * PAGE_W + COUNT_W + FLAG_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((STATUS_W + PAGE_W + FLAG_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT   = 2'd2;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_MAP    = 1'b1;

    typedef struct packed {
        logic                load;
        logic                init_step;
        logic                clr_step;
        logic                alloc;
        logic                cache_fill;
        logic                map_write;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_hit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic init_last;
        logic clr_last;
        logic cache_hit;
        logic dir_present;
        logic slots_full;
        logic entry_present;
        logic count_zero;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== rtl/core/tlpt_ram.sv =====
// ----------------------------------------------------------------------------
// tlpt_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/tlpt_datapath.sv =====
// ----------------------------------------------------------------------------
// tlpt_datapath: page table storage and walk registers
// Holds the directory and table memories, the current command, the slot
// allocator, the last-directory cache and the result register.
// ----------------------------------------------------------------------------
module tlpt_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tlpt_pkg::ctrl_cmd_t            cmd,
    output tlpt_pkg::ctrl_sts_t            sts,
    input  logic [tlpt_pkg::PAGE_W-1:0]    in_virt_page,
    input  logic [tlpt_pkg::PAGE_W-1:0]    in_phys_page,
    input  logic [tlpt_pkg::COUNT_W-1:0]   in_page_count,
    input  logic [tlpt_pkg::FLAG_W-1:0]    in_entry_flags,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [tlpt_pkg::STATUS_W-1:0]  out_status,
    output logic [tlpt_pkg::PAGE_W-1:0]    out_found_page,
    output logic [tlpt_pkg::FLAG_W-1:0]    out_found_flags
);

    logic [tlpt_pkg::PAGE_W-1:0]   vp_reg, vp_next;
    logic [tlpt_pkg::PAGE_W-1:0]   pp_reg, pp_next;
    logic [tlpt_pkg::COUNT_W-1:0]  cnt_reg, cnt_next;
    logic [tlpt_pkg::FLAG_W-1:0]   flags_reg, flags_next;
    logic                          cache_valid_reg, cache_valid_next;
    logic [tlpt_pkg::DIR_W-1:0]    cache_dir_reg, cache_dir_next;
    logic [tlpt_pkg::SLOT_W-1:0]   cache_slot_reg, cache_slot_next;
    logic [tlpt_pkg::NF_W-1:0]     next_free_reg, next_free_next;
    logic [tlpt_pkg::DIR_W-1:0]    init_cnt_reg, init_cnt_next;
    logic [tlpt_pkg::TAB_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [tlpt_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [tlpt_pkg::PAGE_W-1:0]   out_page_reg, out_page_next;
    logic [tlpt_pkg::FLAG_W-1:0]   out_flags_reg, out_flags_next;

    logic [tlpt_pkg::DIR_W-1:0]    cur_dir;
    logic [tlpt_pkg::TAB_W-1:0]    cur_tab;
    logic [tlpt_pkg::SLOT_W-1:0]   free_slot;

    logic                          dir_wr_en;
    logic [tlpt_pkg::DIR_W-1:0]    dir_wr_addr;
    logic [tlpt_pkg::DWORD_W-1:0]  dir_wr_data;
    logic [tlpt_pkg::DWORD_W-1:0]  dir_rd_data;

    logic                          tab_wr_en;
    logic [tlpt_pkg::TADDR_W-1:0]  tab_wr_addr;
    logic [tlpt_pkg::ENTRY_W-1:0]  tab_wr_data;
    logic [tlpt_pkg::TADDR_W-1:0]  tab_rd_addr;
    logic [tlpt_pkg::ENTRY_W-1:0]  tab_rd_data;

    assign cur_dir   = vp_reg[tlpt_pkg::TAB_W +: tlpt_pkg::DIR_W];
    assign cur_tab   = vp_reg[tlpt_pkg::TAB_W-1:0];
    assign free_slot = next_free_reg[tlpt_pkg::SLOT_W-1:0];

    // Directory: written by the post-reset sweep and by slot allocation,
    // read continuously at the directory index of the current page.
    always_comb
    begin
        dir_wr_en   = cmd.init_step | cmd.alloc;
        dir_wr_addr = cmd.init_step ? init_cnt_reg : cur_dir;
        dir_wr_data = cmd.init_step ? '0 : {1'b1, free_slot};
    end

    tlpt_ram #(
        .WIDTH (tlpt_pkg::DWORD_W),
        .DEPTH (tlpt_pkg::DIR_ENTRIES)
    ) u_dir_ram (
        .clk     (clk),
        .wr_en   (dir_wr_en),
        .wr_addr (dir_wr_addr),
        .wr_data (dir_wr_data),
        .rd_addr (cur_dir),
        .rd_data (dir_rd_data)
    );

    // Table store: a fresh slot is zeroed entry by entry before use.
    always_comb
    begin
        tab_wr_en = cmd.clr_step | cmd.map_write;
        if (cmd.clr_step)
        begin
            tab_wr_addr = {free_slot, clr_cnt_reg};
            tab_wr_data = '0;
        end
        else
        begin
            tab_wr_addr = {cache_slot_reg, cur_tab};
            tab_wr_data = {1'b1, flags_reg, pp_reg};
        end
        tab_rd_addr = {dir_rd_data[tlpt_pkg::SLOT_W-1:0], cur_tab};
    end

    tlpt_ram #(
        .WIDTH (tlpt_pkg::ENTRY_W),
        .DEPTH (tlpt_pkg::TDEPTH)
    ) u_table_ram (
        .clk     (clk),
        .wr_en   (tab_wr_en),
        .wr_addr (tab_wr_addr),
        .wr_data (tab_wr_data),
        .rd_addr (tab_rd_addr),
        .rd_data (tab_rd_data)
    );

    always_comb
    begin
        vp_next          = vp_reg;
        pp_next          = pp_reg;
        cnt_next         = cnt_reg;
        flags_next       = flags_reg;
        cache_valid_next = cache_valid_reg;
        cache_dir_next   = cache_dir_reg;
        cache_slot_next  = cache_slot_reg;
        next_free_next   = next_free_reg;
        init_cnt_next    = init_cnt_reg;
        clr_cnt_next     = clr_cnt_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        out_status_next  = out_status_reg;
        out_page_next    = out_page_reg;
        out_flags_next   = out_flags_reg;

        if (cmd.load)
        begin
            vp_next    = in_virt_page;
            pp_next    = in_phys_page;
            cnt_next   = (in_page_count > tlpt_pkg::MAX_RUN) ? tlpt_pkg::MAX_RUN
                                                             : in_page_count;
            flags_next = in_entry_flags;
        end
        if (cmd.map_write)
        begin
            vp_next  = vp_reg + 1'b1;
            pp_next  = pp_reg + 1'b1;
            cnt_next = cnt_reg - 1'b1;
        end
        if (cmd.init_step)
        begin
            init_cnt_next = init_cnt_reg + 1'b1;
        end
        if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        if (cmd.cache_fill)
        begin
            cache_valid_next = 1'b1;
            cache_dir_next   = cur_dir;
            cache_slot_next  = dir_rd_data[tlpt_pkg::SLOT_W-1:0];
        end
        if (cmd.alloc)
        begin
            cache_valid_next = 1'b1;
            cache_dir_next   = cur_dir;
            cache_slot_next  = free_slot;
            next_free_next   = next_free_reg + 1'b1;
        end
        if (cmd.out_load)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.out_status;
            out_page_next   = cmd.out_hit ? tab_rd_data[tlpt_pkg::PAGE_W-1:0] : '0;
            out_flags_next  = cmd.out_hit
                ? tab_rd_data[tlpt_pkg::PAGE_W +: tlpt_pkg::FLAG_W] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_valid_reg <= 1'b0;
            next_free_reg   <= '0;
            init_cnt_reg    <= '0;
            clr_cnt_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            cache_valid_reg <= cache_valid_next;
            next_free_reg   <= next_free_next;
            init_cnt_reg    <= init_cnt_next;
            clr_cnt_reg     <= clr_cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vp_reg         <= vp_next;
        pp_reg         <= pp_next;
        cnt_reg        <= cnt_next;
        flags_reg      <= flags_next;
        cache_dir_reg  <= cache_dir_next;
        cache_slot_reg <= cache_slot_next;
        out_status_reg <= out_status_next;
        out_page_reg   <= out_page_next;
        out_flags_reg  <= out_flags_next;
    end

    always_comb
    begin
        sts.init_last     = &init_cnt_reg;
        sts.clr_last      = &clr_cnt_reg;
        sts.cache_hit     = cache_valid_reg && (cache_dir_reg == cur_dir);
        sts.dir_present   = dir_rd_data[tlpt_pkg::DWORD_W-1];
        sts.slots_full    = next_free_reg >= tlpt_pkg::NF_W'(tlpt_pkg::TABLE_SLOTS);
        sts.entry_present = tab_rd_data[tlpt_pkg::ENTRY_W-1];
        sts.count_zero    = (cnt_reg == '0);
        sts.out_free      = ~out_valid_reg | out_ready;
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_found_page  = out_page_reg;
    assign out_found_flags = out_flags_reg;

endmodule

// ===== rtl/core/tlpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlpt_ctrl: sequencer of the page table engine
// Runs the directory sweep after reset, the two-read lookup and the map walk
// with slot allocation, and hands results to the output register.
// ----------------------------------------------------------------------------
module tlpt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_ready,
    input  tlpt_pkg::ctrl_sts_t sts,
    output tlpt_pkg::ctrl_cmd_t cmd
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_LREAD = 4'd2;
    localparam logic [3:0] S_LDIR  = 4'd3;
    localparam logic [3:0] S_LTAB  = 4'd4;
    localparam logic [3:0] S_WALK  = 4'd5;
    localparam logic [3:0] S_DCHK  = 4'd6;
    localparam logic [3:0] S_CLEAR = 4'd7;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            S_INIT:
            begin
                cmd.init_step = 1'b1;
                if (sts.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_command == tlpt_pkg::CMD_MAP) ? S_WALK : S_LREAD;
                end
            end
            S_LREAD:
            begin
                state_next = S_LDIR;
            end
            S_LDIR:
            begin
                if (sts.dir_present)
                begin
                    state_next = S_LTAB;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = tlpt_pkg::ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
            end
            S_LTAB:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_hit    = sts.entry_present;
                    cmd.out_status = sts.entry_present ? tlpt_pkg::ST_OK
                                                       : tlpt_pkg::ST_NOT_FOUND;
                    state_next     = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (sts.count_zero)
                begin
                    if (sts.out_free)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = tlpt_pkg::ST_OK;
                        state_next     = S_IDLE;
                    end
                end
                else if (sts.cache_hit)
                begin
                    cmd.map_write = 1'b1;
                end
                else
                begin
                    // The directory read of this page lands next cycle.
                    state_next = S_DCHK;
                end
            end
            S_DCHK:
            begin
                if (sts.dir_present)
                begin
                    cmd.cache_fill = 1'b1;
                    state_next     = S_WALK;
                end
                else if (!sts.slots_full)
                begin
                    state_next = S_CLEAR;
                end
                else if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = tlpt_pkg::ST_NO_SLOT;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.alloc  = 1'b1;
                    state_next = S_WALK;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A table entry is written only through a directory entry that is known.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.map_write |-> sts.cache_hit && !sts.count_zero)
        else $error("map write without a resolved directory entry");

    // A slot is handed out only after its full clearing pass, and only if free.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc |-> cmd.clr_step && sts.clr_last && !sts.slots_full)
        else $error("slot allocated before clearing or beyond the last slot");

    // A result never overwrites one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded while output register is held");

    // Nothing is accepted or written to the table store during the reset sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INIT) |-> !in_ready && !cmd.map_write && !cmd.clr_step)
        else $error("activity during the directory sweep");

    // The clearing counter only moves while a fresh slot is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |=> (state_reg == S_CLEAR) || (state_reg == S_WALK))
        else $error("clearing pass left unexpectedly");

endmodule

// ===== rtl/core/two_level_page_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top: two-level page table with lookup and map
//
// Input beats on the s_ channel carry one command each: a lookup of one page
// or a map of a run of consecutive pages. Every command yields exactly one
// result beat on the m_ channel with a status and, for a lookup hit, the
// physical page and flags.
// After reset the directory is swept clear, one entry per cycle, across all
// DIR_ENTRIES entries (1024); s_tready stays low during the sweep.
// A lookup reads the directory and then the table entry from their RAMs, one
// registered read each, in states LREAD, LDIR and LTAB: the result is
// registered from LTAB, or from LDIR when the directory entry is absent.
// A map writes one table entry per cycle while pages stay in the directory
// entry last used; entering another directory entry first reads it in DCHK,
// and allocating a fresh slot first clears its TABLE_ENTRIES entries (1024).
// Otherwise, a map's result is registered once all of its pages are written.
// One command is in work at a time; the next beat is taken the cycle after
// the result is registered. A stalled m_tready holds the result register, and
// the engine then waits with its finished result until the register frees.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // virt_page[19:0], phys_page[39:20], page_count[60:40],
    // entry_flags[69:61], zero fill above
    input  logic [tlpt_pkg::IN_DATA_W-1:0]     s_tdata,
    // command[0]
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status[1:0], found_page[21:2], found_flags[30:22], zero fill above
    output logic [tlpt_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int VP_LSB  = 0;
    localparam int PP_LSB  = VP_LSB + tlpt_pkg::PAGE_W;
    localparam int CNT_LSB = PP_LSB + tlpt_pkg::PAGE_W;
    localparam int FLG_LSB = CNT_LSB + tlpt_pkg::COUNT_W;
    localparam int OUT_USED = tlpt_pkg::STATUS_W + tlpt_pkg::PAGE_W + tlpt_pkg::FLAG_W;

    tlpt_pkg::ctrl_cmd_t           cmd;
    tlpt_pkg::ctrl_sts_t           sts;
    logic [tlpt_pkg::STATUS_W-1:0] res_status;
    logic [tlpt_pkg::PAGE_W-1:0]   res_page;
    logic [tlpt_pkg::FLAG_W-1:0]   res_flags;

    tlpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_command (s_tuser),
        .in_ready   (s_tready),
        .sts        (sts),
        .cmd        (cmd)
    );

    tlpt_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_virt_page    (s_tdata[VP_LSB +: tlpt_pkg::PAGE_W]),
        .in_phys_page    (s_tdata[PP_LSB +: tlpt_pkg::PAGE_W]),
        .in_page_count   (s_tdata[CNT_LSB +: tlpt_pkg::COUNT_W]),
        .in_entry_flags  (s_tdata[FLG_LSB +: tlpt_pkg::FLAG_W]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (res_status),
        .out_found_page  (res_page),
        .out_found_flags (res_flags)
    );

    assign m_tdata = {{(tlpt_pkg::OUT_DATA_W - OUT_USED){1'b0}},
                      res_flags, res_page, res_status};

endmodule

// ===== verif/two_level_page_table_engine_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top_tb: lookup and map regression
// Drives lookup and map commands into the engine and keeps its own copy of
// the directory, the table slots and the slot allocator. Every result beat is
// checked field by field against the oldest predicted walk, under several
// mixes of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module two_level_page_table_engine_top_tb;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 175;

    localparam logic OP_LOOKUP = tlpt_pkg::CMD_LOOKUP;
    localparam logic OP_MAP    = tlpt_pkg::CMD_MAP;

    typedef struct packed {
        logic                          cmd;
        logic [tlpt_pkg::PAGE_W-1:0]   vp;
        logic [tlpt_pkg::PAGE_W-1:0]   pp;
        logic [tlpt_pkg::COUNT_W-1:0]  count;
        logic [tlpt_pkg::FLAG_W-1:0]   flags;
    } walk_cmd_t;

    typedef struct packed {
        logic [tlpt_pkg::STATUS_W-1:0] status;
        logic [tlpt_pkg::PAGE_W-1:0]   page;
        logic [tlpt_pkg::FLAG_W-1:0]   flags;
    } walk_result_t;

    class page_walk_scoreboard;
        logic                         dir_live [tlpt_pkg::DIR_ENTRIES];
        logic [tlpt_pkg::SLOT_W-1:0]  dir_slot_no [tlpt_pkg::DIR_ENTRIES];
        logic [tlpt_pkg::ENTRY_W-1:0] pte [tlpt_pkg::TABLE_SLOTS * tlpt_pkg::TABLE_ENTRIES];
        int                           slots_taken;
        int                           live_dirs [$];
        logic [tlpt_pkg::PAGE_W-1:0]  mapped_pages [$];
        walk_result_t                 expected_walks [$];
        int                           mismatches;

        function new();
            foreach (dir_live[i])
            begin
                dir_live[i]    = 1'b0;
                dir_slot_no[i] = '0;
            end
            foreach (pte[i])
                pte[i] = '0;
            slots_taken = 0;
            mismatches  = 0;
        endfunction

        function walk_result_t walk_or_map(walk_cmd_t c);
            walk_result_t                r;
            int unsigned                 n;
            int unsigned                 d;
            int unsigned                 pos;
            logic [tlpt_pkg::PAGE_W-1:0] v;
            logic [tlpt_pkg::PAGE_W-1:0] p;
            logic                        stop;
            r        = '0;
            r.status = tlpt_pkg::ST_OK;
            stop     = 1'b0;
            if (c.cmd == tlpt_pkg::CMD_LOOKUP)
            begin
                d = (c.vp / tlpt_pkg::TABLE_ENTRIES) % tlpt_pkg::DIR_ENTRIES;
                if (!dir_live[d])
                    r.status = tlpt_pkg::ST_NOT_FOUND;
                else
                begin
                    pos = dir_slot_no[d] * tlpt_pkg::TABLE_ENTRIES
                          + c.vp % tlpt_pkg::TABLE_ENTRIES;
                    if (!pte[pos][tlpt_pkg::ENTRY_W-1])
                        r.status = tlpt_pkg::ST_NOT_FOUND;
                    else
                    begin
                        r.page  = pte[pos][tlpt_pkg::PAGE_W-1:0];
                        r.flags = pte[pos][tlpt_pkg::PAGE_W +: tlpt_pkg::FLAG_W];
                    end
                end
            end
            else
            begin
                n = (c.count > tlpt_pkg::MAX_RUN) ? tlpt_pkg::MAX_RUN : c.count;
                for (int unsigned i = 0; i < n && !stop; i++)
                begin
                    v = c.vp + tlpt_pkg::PAGE_W'(i);
                    p = c.pp + tlpt_pkg::PAGE_W'(i);
                    d = (v / tlpt_pkg::TABLE_ENTRIES) % tlpt_pkg::DIR_ENTRIES;
                    if (!dir_live[d])
                    begin
                        if (slots_taken >= tlpt_pkg::TABLE_SLOTS)
                        begin
                            // The run stops here; pages already written stay.
                            r.status = tlpt_pkg::ST_NO_SLOT;
                            stop     = 1'b1;
                        end
                        else
                        begin
                            for (int k = 0; k < tlpt_pkg::TABLE_ENTRIES; k++)
                                pte[slots_taken * tlpt_pkg::TABLE_ENTRIES + k] = '0;
                            dir_slot_no[d] = tlpt_pkg::SLOT_W'(slots_taken);
                            dir_live[d]    = 1'b1;
                            slots_taken++;
                            live_dirs.push_back(d);
                        end
                    end
                    if (!stop)
                    begin
                        pos = (dir_slot_no[d] % tlpt_pkg::TABLE_SLOTS) * tlpt_pkg::TABLE_ENTRIES
                              + v % tlpt_pkg::TABLE_ENTRIES;
                        pte[pos] = {1'b1, c.flags, p};
                    end
                end
            end
            return r;
        endfunction

        function void note_command(walk_cmd_t c);
            expected_walks.push_back(walk_or_map(c));
            if (c.cmd == tlpt_pkg::CMD_MAP && c.count != 0)
            begin
                mapped_pages.push_back(c.vp);
                if (c.count <= 64)
                    mapped_pages.push_back(c.vp + tlpt_pkg::PAGE_W'(c.count - 1));
                while (mapped_pages.size() > 64)
                    void'(mapped_pages.pop_front());
            end
        endfunction

        task report_mismatch(string what);
            if (mismatches < 50)
                $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_result(logic [tlpt_pkg::OUT_DATA_W-1:0] beat);
            walk_result_t want;
            walk_result_t got;
            got.status = beat[tlpt_pkg::STATUS_W-1:0];
            got.page   = beat[tlpt_pkg::STATUS_W +: tlpt_pkg::PAGE_W];
            got.flags  = beat[tlpt_pkg::STATUS_W + tlpt_pkg::PAGE_W +: tlpt_pkg::FLAG_W];
            if (expected_walks.size() == 0)
            begin
                report_mismatch($sformatf("result beat %h with no command pending", beat));
                return;
            end
            want = expected_walks.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, wanted %0d", got.status, want.status));
            if (got.page !== want.page)
                report_mismatch($sformatf("found_page %h, wanted %h", got.page, want.page));
            if (got.flags !== want.flags)
                report_mismatch($sformatf("found_flags %h, wanted %h", got.flags, want.flags));
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tlpt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            s_tuser = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tlpt_pkg::OUT_DATA_W-1:0] m_tdata;

    page_walk_scoreboard book = new();
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_ticket    = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    two_level_page_table_engine_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: check each accepted beat, then pick next cycle's ready.
    // A hold request from the stimulus side blocks the sink for a long stretch.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            book.check_result(m_tdata);
        if (hold_served != hold_ticket)
        begin
            hold_served = hold_ticket;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic walk_cmd_t walk_cmd(logic cmd, int unsigned vp, int unsigned pp,
                                           int unsigned count, int unsigned flags);
        walk_cmd_t c;
        c.cmd   = cmd;
        c.vp    = tlpt_pkg::PAGE_W'(vp);
        c.pp    = tlpt_pkg::PAGE_W'(pp);
        c.count = tlpt_pkg::COUNT_W'(count);
        c.flags = tlpt_pkg::FLAG_W'(flags);
        return c;
    endfunction

    function automatic int unsigned random_run_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5)
            return 0;
        else if (r < 70)
            return $urandom_range(8, 1);
        else if (r < 90)
            return $urandom_range(64, 9);
        else if (r < 98)
            return $urandom_range(2048, 65);
        // Long runs end at the first directory without a slot.
        return $urandom_range(32'h1F_FFFF, 32'h10_0000);
    endfunction

    function automatic walk_cmd_t random_walk_cmd();
        walk_cmd_t   c;
        int unsigned dir;
        int unsigned r;
        c.pp    = tlpt_pkg::PAGE_W'($urandom);
        c.flags = tlpt_pkg::FLAG_W'($urandom);
        c.count = tlpt_pkg::COUNT_W'(random_run_length());
        dir     = book.live_dirs[$urandom_range(book.live_dirs.size() - 1)];
        r       = $urandom_range(99);
        if ($urandom_range(1) == 0)
        begin
            c.cmd = tlpt_pkg::CMD_LOOKUP;
            if (r < 60 && book.mapped_pages.size() != 0)
                c.vp = book.mapped_pages[$urandom_range(book.mapped_pages.size() - 1)];
            else if (r < 85)
                c.vp = tlpt_pkg::PAGE_W'(dir * tlpt_pkg::TABLE_ENTRIES
                                         + $urandom_range(tlpt_pkg::TABLE_ENTRIES - 1));
            else
                c.vp = tlpt_pkg::PAGE_W'($urandom);
        end
        else
        begin
            c.cmd = tlpt_pkg::CMD_MAP;
            if (r < 80)
                c.vp = tlpt_pkg::PAGE_W'(dir * tlpt_pkg::TABLE_ENTRIES
                                         + $urandom_range(tlpt_pkg::TABLE_ENTRIES - 1));
            else
                c.vp = tlpt_pkg::PAGE_W'($urandom);
        end
        return c;
    endfunction

    // Called just after the clock rises; returns as soon as the engine has taken the beat.
    task send_beat(walk_cmd_t c);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.cmd;
        s_tdata  <= tlpt_pkg::IN_DATA_W'({c.flags, c.count, c.pp, c.vp});
        do
            @(posedge clk);
        while (!s_tready);
        book.note_command(c);
    endtask

    task wait_all_results();
        s_tvalid <= 1'b0;
        while (book.expected_walks.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        walk_cmd_t directed [$];

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty table, then a single page in directory zero.
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h00000, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'hFFFFF, 0, 0, 0));
        directed.push_back(walk_cmd(OP_MAP,    32'h00000, 32'h00000, 1, 9'h000));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h00000, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h00001, 0, 0, 0));
        // Run that wraps both page numbers past the top and overwrites page zero.
        directed.push_back(walk_cmd(OP_MAP,    32'hFFFFE, 32'hFFFFF, 4, 9'h1FF));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'hFFFFF, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h00000, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h00001, 0, 0, 0));
        // A zero-length map leaves its directory untouched.
        directed.push_back(walk_cmd(OP_MAP,    32'h12345, 32'h54321, 0, 9'h0AA));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h12345, 0, 0, 0));
        // Run crossing into a new directory entry.
        directed.push_back(walk_cmd(OP_MAP,    32'h003FE, 32'hABCDE, 5, 9'h0AA));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h00401, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h003FF, 0, 0, 0));
        directed.push_back(walk_cmd(OP_MAP,    32'h80000, 32'h55555, 2, 9'h155));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h80001, 0, 0, 0));
        // Oversized count: saturates and runs until the slots are used up.
        directed.push_back(walk_cmd(OP_MAP,    32'h00400, 32'h7FFFF, 32'h1FFFFF, 9'h100));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h00400, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h037FF, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h03800, 0, 0, 0));
        directed.push_back(walk_cmd(OP_MAP,    32'h03800, 32'h00001, 1, 9'h001));
        // Exactly the full page space, stopped at the next absent directory.
        directed.push_back(walk_cmd(OP_MAP,    32'h80000, 32'h0F0F0, 32'h100000, 9'h0F0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h803FF, 0, 0, 0));
        directed.push_back(walk_cmd(OP_LOOKUP, 32'h80400, 0, 0, 0));
        foreach (directed[i])
            send_beat(directed[i]);
        wait_all_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct   = (phase == 1) ? 47 : (phase == 3) ? 25 : 0;
            sink_stall_pct = (phase == 2) ? 47 : (phase == 3) ? 25 : 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // With the source streaming, a long sink stall backs up the engine.
                if ((phase == 0 || phase == 2) && k == 60)
                    hold_ticket++;
                send_beat(random_walk_cmd());
            end
            wait_all_results();
        end

        repeat (16) @(posedge clk);
        if (book.mismatches == 0 && book.expected_walks.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/tlpt_pkg.sv
rtl/core/tlpt_ram.sv
rtl/core/tlpt_datapath.sv
rtl/core/tlpt_ctrl.sv
rtl/core/two_level_page_table_engine_top.sv
verif/two_level_page_table_engine_top_tb.sv
